// ----- sv/ght_pkg.sv -----
// types and constants shared by the generational handle table
`timescale 1ns / 1ps

package ght_pkg;

  localparam int unsigned SlotsDefault = 256;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         handle_index;
    logic [31:0]        handle_gen;
    logic signed [31:0] data_value;
    logic [31:0]        pos_x_bits;
    logic [31:0]        pos_y_bits;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         out_index;
    logic [31:0]        out_gen;
    logic signed [31:0] read_data;
    logic [31:0]        read_pos_x;
    logic [31:0]        read_pos_y;
    logic [7:0]         active_total;
  } rsp_t;

  typedef struct packed {
    logic               active;
    logic [31:0]        gen;
    logic signed [31:0] data;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
  } slot_t;

endpackage

// ----- sv/ght_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ght_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/generational_handle_table_top.sv -----
// generational handle table: slot memory, free stack and operation sequencer
`timescale 1ns / 1ps

// One operation is accepted when start_i is high and busy_o is low. An add
// that takes a never-used slot, an add on a full table and a handle whose
// index is zero or beyond the used range finish in the cycle they are
// accepted and keep busy_o low. Get, remove and update of an in-range handle
// go through S_CHK; an add that reuses a freed slot goes through S_POP and
// S_BUMP, as the slot and free-stack memories have registered read data and
// are read one after the other. The result word appears on rsp_o for exactly
// one cycle with rsp_valid_o high, in the cycle after the last cycle of the
// operation; the receiver cannot stall it. No clearing pass follows reset.
module generational_handle_table_top #(
  parameter int unsigned SLOTS = ght_pkg::SlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ght_pkg::req_t req_i,
  output logic          busy_o,
  output logic          rsp_valid_o,
  output ght_pkg::rsp_t rsp_o
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CW > 8) ? CW : 8;
  localparam int unsigned SW   = $bits(ght_pkg::slot_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_BUMP = 4'b0100,
    S_CHK  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  ght_pkg::req_t req_q, req_d;
  ght_pkg::rsp_t rsp_q, rsp_d, rsp_n;
  logic          rsp_valid_q, rsp_valid_d;
  logic [CW-1:0] hw_q, hw_d;
  logic [CW-1:0] fd_q, fd_d;
  logic [CW-1:0] live_q, live_d;
  logic [IW-1:0] slot_idx_q, slot_idx_d;

  logic            slot_we;
  logic [IW-1:0]   slot_waddr, slot_raddr;
  ght_pkg::slot_t  slot_wdata, slot_rdata;
  logic [SW-1:0]   slot_rdata_raw;
  logic            stk_we;
  logic [IW-1:0]   stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  logic            done;
  logic            in_range;

  assign in_range = (req_i.handle_index != 8'd0) &&
                    (CmpW'(req_i.handle_index) < CmpW'(hw_q));

  assign slot_rdata = ght_pkg::slot_t'(slot_rdata_raw);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    hw_d        = hw_q;
    fd_d        = fd_q;
    live_d      = live_q;
    slot_idx_d  = slot_idx_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    rsp_n       = '0;
    done        = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = slot_idx_q;
    slot_wdata  = '0;
    slot_raddr  = IW'(req_i.handle_index);
    stk_we      = 1'b0;
    stk_waddr   = IW'(fd_q);
    stk_wdata   = IW'(req_q.handle_index);
    stk_raddr   = IW'(fd_q - CW'(1));

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          if (req_i.op == ght_pkg::OP_ADD) begin
            if (fd_q != '0) begin
              state_d = S_POP;
            end else if (hw_q < CW'(SLOTS)) begin
              slot_we    = 1'b1;
              slot_waddr = IW'(hw_q);
              slot_wdata = '{active: 1'b1, gen: 32'd1, data: req_i.data_value,
                             pos_x: req_i.pos_x_bits, pos_y: req_i.pos_y_bits};
              hw_d       = hw_q + CW'(1);
              live_d     = live_q + CW'(1);
              rsp_n.out_index = 8'(hw_q);
              rsp_n.out_gen   = 32'd1;
              done       = 1'b1;
            end else begin
              rsp_n.status = ght_pkg::STAT_FULL;
              done         = 1'b1;
            end
          end else if (in_range) begin
            state_d = S_CHK;
          end else begin
            rsp_n.status = ght_pkg::STAT_INVALID;
            done         = 1'b1;
          end
        end
      end
      S_POP: begin
        slot_raddr = stk_rdata;
        slot_idx_d = stk_rdata;
        fd_d       = fd_q - CW'(1);
        state_d    = S_BUMP;
      end
      S_BUMP: begin
        slot_we    = 1'b1;
        slot_waddr = slot_idx_q;
        slot_wdata = '{active: 1'b1, gen: slot_rdata.gen + 32'd1, data: req_q.data_value,
                       pos_x: req_q.pos_x_bits, pos_y: req_q.pos_y_bits};
        live_d     = live_q + CW'(1);
        rsp_n.out_index = 8'(slot_idx_q);
        rsp_n.out_gen   = slot_rdata.gen + 32'd1;
        done       = 1'b1;
        state_d    = S_IDLE;
      end
      S_CHK: begin
        slot_waddr = IW'(req_q.handle_index);
        done       = 1'b1;
        state_d    = S_IDLE;
        if (!(slot_rdata.active && (slot_rdata.gen == req_q.handle_gen))) begin
          rsp_n.status = ght_pkg::STAT_INVALID;
        end else begin
          case (req_q.op)
            ght_pkg::OP_GET: begin
              rsp_n.read_data  = slot_rdata.data;
              rsp_n.read_pos_x = slot_rdata.pos_x;
              rsp_n.read_pos_y = slot_rdata.pos_y;
            end
            ght_pkg::OP_REMOVE: begin
              slot_we    = 1'b1;
              slot_wdata = '{active: 1'b0, gen: slot_rdata.gen, data: 32'sd0,
                             pos_x: 32'd0, pos_y: 32'd0};
              stk_we     = 1'b1;
              fd_d       = fd_q + CW'(1);
              live_d     = live_q - CW'(1);
            end
            ght_pkg::OP_UPDATE: begin
              slot_we    = 1'b1;
              slot_wdata = '{active: 1'b1, gen: slot_rdata.gen, data: req_q.data_value,
                             pos_x: req_q.pos_x_bits, pos_y: req_q.pos_y_bits};
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      rsp_d              = rsp_n;
      rsp_d.active_total = 8'(live_d);
      rsp_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      hw_q        <= CW'(1);
      fd_q        <= '0;
      live_q      <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      hw_q        <= hw_d;
      fd_q        <= fd_d;
      live_q      <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rsp_q      <= rsp_d;
    slot_idx_q <= slot_idx_d;
  end

  ght_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (SW'(slot_wdata)),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata_raw)
  );

  ght_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTH
  // the popped slot is counted live only once its bump is written
  a_count_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_BUMP) |->
      ((CW+1)'(fd_q) + (CW+1)'(live_q) + (CW+1)'(1) == (CW+1)'(hw_q)))
    else $error("free and live counts do not add up to the used range");

  a_word_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q != S_IDLE) || $past(start_i))
    else $error("result word without an operation");

  a_bump_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BUMP |-> $past(state_q == S_POP))
    else $error("generation bump without a stack pop");

  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != ght_pkg::STAT_OK) |->
      (rsp_o.out_index == 8'd0) && (rsp_o.out_gen == 32'd0))
    else $error("failed operation returned a handle");
`endif

endmodule

// ----- tb/ght_table_checker.sv -----
// checker for the generational handle table: predicts each result word and compares it
`timescale 1ns / 1ps

module ght_table_checker
  import ght_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic rsp_valid_i,
  input  rsp_t rsp_i,
  output int   pending_o,
  output int   errors_o
);

  logic [31:0] gen_mem    [SLOTS];
  logic        live_mark  [SLOTS];
  logic [31:0] data_mem   [SLOTS];
  logic [31:0] pos_x_mem  [SLOTS];
  logic [31:0] pos_y_mem  [SLOTS];
  logic [7:0]  freed_stack[SLOTS];
  int          freed_depth;
  int          next_fresh;
  int          live_count;
  rsp_t        expected_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      live_mark[i] = 1'b0;
    end
    freed_depth = 0;
    next_fresh  = 1;
    live_count  = 0;
    expected_q.delete();
  endtask

  task automatic predict_table_op(input req_t r, output rsp_t p);
    logic [7:0] idx;
    logic       valid;
    p = '0;
    p.status = STAT_OK;
    idx = r.handle_index;
    if (r.op == OP_ADD) begin
      if (freed_depth > 0) begin
        freed_depth--;
        idx = freed_stack[freed_depth];
        gen_mem[idx] = gen_mem[idx] + 32'd1;
      end else if (next_fresh < SLOTS) begin
        idx = 8'(next_fresh);
        next_fresh++;
        gen_mem[idx] = 32'd1;
      end else begin
        p.status = STAT_FULL;
      end
      if (p.status == STAT_OK) begin
        live_mark[idx] = 1'b1;
        data_mem[idx]  = r.data_value;
        pos_x_mem[idx] = r.pos_x_bits;
        pos_y_mem[idx] = r.pos_y_bits;
        live_count++;
        p.out_index = idx;
        p.out_gen   = gen_mem[idx];
      end
    end else begin
      valid = (idx != 8'd0) && (int'(idx) < next_fresh) && live_mark[idx] &&
              (gen_mem[idx] == r.handle_gen);
      if (!valid) begin
        p.status = STAT_INVALID;
      end else begin
        case (r.op)
          OP_GET: begin
            p.read_data  = data_mem[idx];
            p.read_pos_x = pos_x_mem[idx];
            p.read_pos_y = pos_y_mem[idx];
          end
          OP_REMOVE: begin
            if (freed_depth < SLOTS) begin
              freed_stack[freed_depth] = idx;
              freed_depth++;
            end
            live_mark[idx] = 1'b0;
            data_mem[idx]  = '0;
            pos_x_mem[idx] = '0;
            pos_y_mem[idx] = '0;
            if (live_count > 0) live_count--;
          end
          default: begin
            data_mem[idx]  = r.data_value;
            pos_x_mem[idx] = r.pos_x_bits;
            pos_y_mem[idx] = r.pos_y_bits;
          end
        endcase
      end
    end
    p.active_total = 8'(live_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      clear_table();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (rsp_valid_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: %h", rsp_i));
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(rsp_i.status), 32'(want.status));
          check_field("out_index", 32'(rsp_i.out_index), 32'(want.out_index));
          check_field("out_gen", rsp_i.out_gen, want.out_gen);
          check_field("read_data", rsp_i.read_data, want.read_data);
          check_field("read_pos_x", rsp_i.read_pos_x, want.read_pos_x);
          check_field("read_pos_y", rsp_i.read_pos_y, want.read_pos_y);
          check_field("active_total", 32'(rsp_i.active_total), 32'(want.active_total));
        end
      end
      if (start_i && !busy_i) begin
        predict_table_op(req_i, want);
        expected_q.push_back(want);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/tb_generational_handle_table_top.sv -----
// testbench top for the generational handle table: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_generational_handle_table_top;
  import ght_pkg::*;

  localparam int RandomItems   = 1250;
  localparam int QuietTail     = 150;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] gen;
  } handle_t;

  typedef enum int {
    LOAD_MIXED,
    LOAD_FILL,
    LOAD_DRAIN
  } load_mode_e;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  logic    rsp_valid;
  req_t    req;
  rsp_t    rsp;
  int      pending;
  int      errors;
  int      full_seen = 0;
  int      quiet_cycles = 0;
  handle_t live_q[$];
  handle_t stale_q[$];

  generational_handle_table_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .req_i      (req),
    .busy_o     (busy),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  ght_table_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .rsp_valid_i(rsp_valid),
    .rsp_i      (rsp),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // track handles handed out so the stimulus can present live ones
  always @(posedge clk) begin
    if (rsp_valid && rsp.status == STAT_OK && rsp.out_index != 8'd0) begin
      live_q.push_back('{index: rsp.out_index, gen: rsp.out_gen});
    end
    if (rsp_valid && rsp.status == STAT_FULL) full_seen++;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || rsp_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_word(input op_e op, input logic [7:0] idx,
                                     input logic [31:0] gen, input logic [31:0] dv,
                                     input logic [31:0] px, input logic [31:0] py);
    req_t r;
    r.op           = op;
    r.handle_index = idx;
    r.handle_gen   = gen;
    r.data_value   = dv;
    r.pos_x_bits   = px;
    r.pos_y_bits   = py;
    return r;
  endfunction

  function automatic req_t random_word(input load_mode_e mode);
    req_t    r;
    handle_t h;
    int      roll;
    int      add_pct;
    int      rm_pct;
    r = make_word(op_e'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
                  $urandom, $urandom);
    roll    = $urandom_range(0, 99);
    add_pct = (mode == LOAD_FILL) ? 70 : (mode == LOAD_DRAIN) ? 5 : 35;
    rm_pct  = (mode == LOAD_FILL) ? 5 : (mode == LOAD_DRAIN) ? 70 : 20;
    if (roll < 8) begin
      // plain noise
    end else if (roll < 13 && stale_q.size() > 0) begin
      h = stale_q[$urandom_range(0, stale_q.size() - 1)];
      r.op           = op_e'($urandom_range(1, 3));
      r.handle_index = h.index;
      r.handle_gen   = h.gen;
    end else if (roll < 16 && live_q.size() > 0) begin
      h = live_q[$urandom_range(0, live_q.size() - 1)];
      r.op           = op_e'($urandom_range(1, 3));
      r.handle_index = h.index;
      r.handle_gen   = h.gen ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct || live_q.size() == 0) begin
        r.op = OP_ADD;
      end else begin
        h = live_q[$urandom_range(0, live_q.size() - 1)];
        r.handle_index = h.index;
        r.handle_gen   = h.gen;
        if (roll < add_pct + rm_pct) r.op = OP_REMOVE;
        else r.op = ($urandom_range(0, 1) == 0) ? OP_GET : OP_UPDATE;
      end
    end
    return r;
  endfunction

  task automatic issue_word(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.op == OP_REMOVE) begin
      for (int k = 0; k < live_q.size(); k++) begin
        if (live_q[k].index == r.handle_index && live_q[k].gen == r.handle_gen) begin
          stale_q.push_back(live_q[k]);
          live_q.delete(k);
          break;
        end
      end
      if (stale_q.size() > 64) void'(stale_q.pop_front());
    end
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_results();
    idle_sender(1);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    load_mode_e mode;
    int         mixed_left;
    int         full_mark;
    rst_n = 1'b0;
    start = 1'b0;
    req   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue_word(make_word(OP_GET, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_REMOVE, 8'd0, 32'hffff_ffff, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_ADD, 8'hff, 32'hffff_ffff, 32'h8000_0000, 32'd0,
                         32'hffff_ffff));
    issue_word(make_word(OP_ADD, 8'd0, 32'd0, 32'h7fff_ffff, 32'hffff_ffff, 32'd0));
    issue_word(make_word(OP_GET, 8'd1, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_GET, 8'd2, 32'd1, 32'hffff_ffff, 32'hffff_ffff,
                         32'hffff_ffff));
    issue_word(make_word(OP_UPDATE, 8'd1, 32'd1, 32'hffff_ffff, 32'h5a5a_5a5a,
                         32'ha5a5_a5a5));
    issue_word(make_word(OP_GET, 8'd1, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_GET, 8'd1, 32'd0, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_GET, 8'hff, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_UPDATE, 8'd0, 32'd1, 32'h1234_5678, 32'd1, 32'd2));
    issue_word(make_word(OP_REMOVE, 8'd2, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_GET, 8'd2, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_REMOVE, 8'd2, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_UPDATE, 8'd2, 32'd1, 32'h0bad_0bad, 32'd3, 32'd4));
    issue_word(make_word(OP_ADD, 8'd0, 32'd0, 32'd0, 32'h3f80_0000, 32'hbf80_0000));
    issue_word(make_word(OP_GET, 8'd2, 32'd2, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_GET, 8'd2, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_REMOVE, 8'd1, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_REMOVE, 8'd2, 32'd2, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_ADD, 8'd0, 32'd0, 32'd11, 32'd12, 32'd13));
    issue_word(make_word(OP_ADD, 8'd0, 32'd0, 32'd21, 32'd22, 32'd23));
    issue_word(make_word(OP_ADD, 8'd0, 32'd0, 32'd31, 32'd32, 32'd33));
    issue_word(make_word(OP_GET, 8'd3, 32'd1, 32'd0, 32'd0, 32'd0));
    issue_word(make_word(OP_UPDATE, 8'd3, 32'd1, 32'h8000_0001, 32'h7f80_0000,
                         32'hff80_0000));
    wait_all_results();

    mode       = LOAD_MIXED;
    mixed_left = 150;
    full_mark  = 0;
    for (int n = 0; n < RandomItems; n++) begin
      case (mode)
        LOAD_MIXED: begin
          mixed_left--;
          if (mixed_left <= 0) begin
            mode      = LOAD_FILL;
            full_mark = full_seen;
          end
        end
        LOAD_FILL: begin
          if (full_seen >= full_mark + 6) begin
            wait_all_results();
            mode = LOAD_DRAIN;
          end
        end
        default: begin
          if (live_q.size() < 3) begin
            mode       = LOAD_MIXED;
            mixed_left = 120;
          end
        end
      endcase
      issue_word(random_word(mode));
      if (n < RandomItems - QuietTail && (n % 200) >= 40 && $urandom_range(0, 5) == 0) begin
        idle_sender($urandom_range(1, 15));
      end
    end

    wait_all_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- generational_handle_table_top.f -----
sv/ght_pkg.sv
sv/ght_ram.sv
sv/generational_handle_table_top.sv
tb/ght_table_checker.sv
tb/tb_generational_handle_table_top.sv
